/* hdl/smcv_pkg.sv */
// ----------------------------------------------------------------------------
// Stereo matching cost volume package
// Widths, register codes, reset values and the types shared by the blocks.
// ----------------------------------------------------------------------------
package smcv_pkg;

  localparam int MAX_LABELS_DEF = 32;

  localparam int PIX_W      = 8;
  localparam int CH_N       = 3;
  localparam int RGB_W      = PIX_W * CH_N;
  localparam int COST_W     = 18;
  localparam int LABEL_W    = 5;
  localparam int CNT_W      = 6;
  localparam int COL_W      = 6;
  localparam int NL_W       = 6;
  localparam int NC_W       = 2;
  localparam int TRUNC_W    = 10;
  localparam int MAXSUM_W   = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int PRIME      = 4;

  localparam logic [COL_W-1:0] COL_MAX = 6'd63;

  localparam int PIX_MAX    = 255;
  localparam int PIX_MAX_SQ = 255 * 255;

  localparam int NL_RESET    = 16;
  localparam int NC_RESET    = 3;
  localparam int BT_RESET    = 1;
  localparam int SQ_RESET    = 0;
  localparam int TRUNC_RESET = 255;

  localparam int MAXSUM_RESET = NC_RESET * TRUNC_RESET;
  localparam int WORST_RESET  = NC_RESET * PIX_MAX;
  localparam int BAD_RESET    = (WORST_RESET < MAXSUM_RESET) ? WORST_RESET : MAXSUM_RESET;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_LABELS = 3'd0,
    REG_NUM_COLORS = 3'd1,
    REG_USE_BT     = 3'd2,
    REG_USE_SQ     = 3'd3,
    REG_TRUNC      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELAYED,
    ST_END
  } state_t;

  typedef struct packed {
    logic [NL_W-1:0]     labels;
    logic [NC_W-1:0]     colors;
    logic                use_bt;
    logic                use_sq;
    logic [MAXSUM_W-1:0] max_sum;
    logic [COST_W-1:0]   bad;
  } cfg_t;

  typedef struct packed {
    logic               write;
    logic               base;
    logic [CNT_W-1:0]   rd_age;
    logic               emit;
    logic [LABEL_W-1:0] label;
    logic               pixel_last;
    logic               row_last;
    logic               x_zero;
    logic               oob;
    logic               at_edge;
  } cmd_t;

endpackage

/* hdl/smcv_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Register file with the derived label count, colour count and cost limits.
// ----------------------------------------------------------------------------
module smcv_cfg #(
  parameter int MAX_LABELS = smcv_pkg::MAX_LABELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [smcv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smcv_pkg::CFG_DATA_W-1:0]     cfg_data,
  output smcv_pkg::cfg_t                      cfg
);

  logic [smcv_pkg::NL_W-1:0]    num_labels;
  logic [smcv_pkg::NC_W-1:0]    num_colors;
  logic                         use_birchfield;
  logic                         use_squared;
  logic [smcv_pkg::TRUNC_W-1:0] trunc_limit;

  logic [smcv_pkg::NL_W-1:0]     labels_eff;
  logic [smcv_pkg::NC_W-1:0]     colors_eff;
  logic [smcv_pkg::MAXSUM_W-1:0] max_sum;
  logic [smcv_pkg::COST_W-1:0]   worst;
  smcv_pkg::cfg_t                cfg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_labels     <= smcv_pkg::NL_W'(smcv_pkg::NL_RESET);
      num_colors     <= smcv_pkg::NC_W'(smcv_pkg::NC_RESET);
      use_birchfield <= 1'(smcv_pkg::BT_RESET);
      use_squared    <= 1'(smcv_pkg::SQ_RESET);
      trunc_limit    <= smcv_pkg::TRUNC_W'(smcv_pkg::TRUNC_RESET);
    end else if (cfg_we) begin
      case (smcv_pkg::cfg_reg_t'(cfg_index))
        smcv_pkg::REG_NUM_LABELS: num_labels     <= cfg_data[smcv_pkg::NL_W-1:0];
        smcv_pkg::REG_NUM_COLORS: num_colors     <= cfg_data[smcv_pkg::NC_W-1:0];
        smcv_pkg::REG_USE_BT:     use_birchfield <= cfg_data[0];
        smcv_pkg::REG_USE_SQ:     use_squared    <= cfg_data[0];
        smcv_pkg::REG_TRUNC:      trunc_limit    <= cfg_data[smcv_pkg::TRUNC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_labels == '0) begin
      labels_eff = smcv_pkg::NL_W'(1);
    end else if (num_labels > smcv_pkg::NL_W'(MAX_LABELS)) begin
      labels_eff = smcv_pkg::NL_W'(MAX_LABELS);
    end else begin
      labels_eff = num_labels;
    end
    colors_eff = (num_colors == '0) ? smcv_pkg::NC_W'(1) : num_colors;
    if (use_squared) begin
      max_sum = smcv_pkg::MAXSUM_W'(trunc_limit) * smcv_pkg::MAXSUM_W'(trunc_limit);
      worst   = smcv_pkg::COST_W'(colors_eff) * smcv_pkg::COST_W'(smcv_pkg::PIX_MAX_SQ);
    end else begin
      max_sum = smcv_pkg::MAXSUM_W'(colors_eff) * smcv_pkg::MAXSUM_W'(trunc_limit);
      worst   = smcv_pkg::COST_W'(colors_eff) * smcv_pkg::COST_W'(smcv_pkg::PIX_MAX);
    end
    cfg_next.labels  = labels_eff;
    cfg_next.colors  = colors_eff;
    cfg_next.use_bt  = use_birchfield;
    cfg_next.use_sq  = use_squared;
    cfg_next.max_sum = max_sum;
    cfg_next.bad     = (smcv_pkg::MAXSUM_W'(worst) < max_sum) ? worst
                                                              : max_sum[smcv_pkg::COST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.labels  <= smcv_pkg::NL_W'(smcv_pkg::NL_RESET);
      cfg.colors  <= smcv_pkg::NC_W'(smcv_pkg::NC_RESET);
      cfg.use_bt  <= 1'(smcv_pkg::BT_RESET);
      cfg.use_sq  <= 1'(smcv_pkg::SQ_RESET);
      cfg.max_sum <= smcv_pkg::MAXSUM_W'(smcv_pkg::MAXSUM_RESET);
      cfg.bad     <= smcv_pkg::COST_W'(smcv_pkg::BAD_RESET);
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

/* hdl/smcv_ctrl.sv */
// ----------------------------------------------------------------------------
// Cost volume controller
// Accepts requests, tracks the row column and sequences each pixel's labels.
// ----------------------------------------------------------------------------
module smcv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           line_end,
  output logic           in_stall,
  input  logic           advance,
  input  smcv_pkg::cfg_t cfg,
  output smcv_pkg::cmd_t cmd
);

  smcv_pkg::state_t state, state_next;

  logic [smcv_pkg::CNT_W-1:0] k, k_next;
  logic [smcv_pkg::COL_W-1:0] x, x_next;
  logic [smcv_pkg::COL_W-1:0] col, col_next;
  logic                       end_pend, end_pend_next;

  logic                       accept;
  logic                       job_done;
  logic [smcv_pkg::CNT_W-1:0] last_k;
  logic [smcv_pkg::CNT_W-1:0] d;

  assign accept   = in_valid && !in_stall;
  assign last_k   = smcv_pkg::CNT_W'(cfg.labels) + smcv_pkg::CNT_W'(smcv_pkg::PRIME - 1);
  assign job_done = (state != smcv_pkg::ST_IDLE) && advance && (k == last_k);
  assign d        = k - smcv_pkg::CNT_W'(smcv_pkg::PRIME);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= smcv_pkg::ST_IDLE;
      k        <= '0;
      x        <= '0;
      col      <= '0;
      end_pend <= 1'b0;
    end else begin
      state    <= state_next;
      k        <= k_next;
      x        <= x_next;
      col      <= col_next;
      end_pend <= end_pend_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      smcv_pkg::ST_IDLE: begin
        if (accept) begin
          if (col != '0) begin
            state_next = smcv_pkg::ST_DELAYED;
          end else if (line_end) begin
            state_next = smcv_pkg::ST_END;
          end
        end
      end
      smcv_pkg::ST_DELAYED: begin
        if (job_done) begin
          state_next = end_pend ? smcv_pkg::ST_END : smcv_pkg::ST_IDLE;
        end
      end
      smcv_pkg::ST_END: begin
        if (job_done) begin
          state_next = smcv_pkg::ST_IDLE;
        end
      end
      default: state_next = smcv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    k_next        = k;
    x_next        = x;
    col_next      = col;
    end_pend_next = end_pend;
    if (accept) begin
      k_next        = '0;
      x_next        = (col != '0) ? col - smcv_pkg::COL_W'(1) : col;
      end_pend_next = line_end;
      if (line_end) begin
        col_next = '0;
      end else if (col != smcv_pkg::COL_MAX) begin
        col_next = col + smcv_pkg::COL_W'(1);
      end
    end else if ((state != smcv_pkg::ST_IDLE) && advance) begin
      if (k == last_k) begin
        k_next = '0;
        x_next = x + smcv_pkg::COL_W'(1);
      end else begin
        k_next = k + smcv_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    in_stall       = (state != smcv_pkg::ST_IDLE);
    cmd.write      = in_valid && (state == smcv_pkg::ST_IDLE);
    cmd.base       = (state == smcv_pkg::ST_DELAYED);
    cmd.rd_age     = (k == '0) ? '0
                   : k - smcv_pkg::CNT_W'(1) + smcv_pkg::CNT_W'(cmd.base);
    cmd.emit       = (state != smcv_pkg::ST_IDLE) &&
                     (k >= smcv_pkg::CNT_W'(smcv_pkg::PRIME));
    cmd.label      = d[smcv_pkg::LABEL_W-1:0];
    cmd.pixel_last = (d == (smcv_pkg::CNT_W'(cfg.labels) - smcv_pkg::CNT_W'(1)));
    cmd.row_last   = cmd.pixel_last && (state == smcv_pkg::ST_END);
    cmd.x_zero     = (x == '0);
    cmd.oob        = (smcv_pkg::COL_W'(d) > x);
    cmd.at_edge    = (smcv_pkg::COL_W'(d) == x);
  end

`ifndef SYNTHESIS
  a_hold_label: assert property (@(posedge clk) disable iff (rst)
    (state != smcv_pkg::ST_IDLE && !advance) |=> $stable(k))
    else $error("label counter moved while output stalled");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && line_end) |=> (col == '0))
    else $error("column count not cleared at row end");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !line_end && col != smcv_pkg::COL_MAX) |=> (col == $past(col) + 1'b1))
    else $error("column count did not advance");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == smcv_pkg::ST_END && advance && k == last_k) |=> (state == smcv_pkg::ST_IDLE))
    else $error("row end pixel did not return to idle");
`endif

endmodule

/* hdl/smcv_dp.sv */
// ----------------------------------------------------------------------------
// Cost volume datapath
// Right pixel window memory, left history, dissimilarity and cost stages.
// ----------------------------------------------------------------------------
module smcv_dp #(
  parameter int MAX_LABELS = smcv_pkg::MAX_LABELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  smcv_pkg::cmd_t                    cmd,
  input  smcv_pkg::cfg_t                    cfg,
  input  logic [smcv_pkg::PIX_W-1:0]        left_ch0,
  input  logic [smcv_pkg::PIX_W-1:0]        left_ch1,
  input  logic [smcv_pkg::PIX_W-1:0]        left_ch2,
  input  logic [smcv_pkg::PIX_W-1:0]        right_ch0,
  input  logic [smcv_pkg::PIX_W-1:0]        right_ch1,
  input  logic [smcv_pkg::PIX_W-1:0]        right_ch2,
  output logic                              advance,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [smcv_pkg::COST_W-1:0]       cost,
  output logic [smcv_pkg::LABEL_W-1:0]      disparity,
  output logic                              pixel_last,
  output logic                              row_last
);

  localparam int AW    = $clog2(MAX_LABELS + 2);
  localparam int DEPTH = 2 ** AW;

  localparam int PW = smcv_pkg::PIX_W;
  localparam int RW = smcv_pkg::RGB_W;

  logic [RW-1:0] mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] rd_data;

  logic [RW-1:0] rw_m, rw_c, rw_p;
  logic [RW-1:0] lh0, lh1, lh2;
  logic [RW-1:0] lc, ll, lr, rl;

  logic [PW-1:0]                 diff_c [smcv_pkg::CH_N];
  logic                          b_valid;
  logic [PW-1:0]                 b_diff [smcv_pkg::CH_N];
  logic                          b_oob;
  logic [smcv_pkg::LABEL_W-1:0]  b_label;
  logic                          b_plast;
  logic                          b_rlast;

  logic [smcv_pkg::COST_W-1:0]   sum;
  logic [smcv_pkg::COST_W-1:0]   cost_next;

  function automatic logic [PW-1:0] pix_diff(input logic       bt,
                                             input logic [PW-1:0] c1,
                                             input logic [PW-1:0] n1l,
                                             input logic [PW-1:0] n1r,
                                             input logic [PW-1:0] c2,
                                             input logic [PW-1:0] n2l,
                                             input logic [PW-1:0] n2r);
    logic [PW:0]   s1l, s1r, s2l, s2r;
    logic [PW-1:0] h1l, h1r, h2l, h2r;
    logic [PW-1:0] mn1, mx1, mn2, mx2, d1, d2;
    s1l = {1'b0, c1} + {1'b0, n1l};
    s1r = {1'b0, c1} + {1'b0, n1r};
    s2l = {1'b0, c2} + {1'b0, n2l};
    s2r = {1'b0, c2} + {1'b0, n2r};
    h1l = s1l[PW:1];
    h1r = s1r[PW:1];
    h2l = s2l[PW:1];
    h2r = s2r[PW:1];
    mn1 = (h1l < h1r) ? h1l : h1r;
    mn1 = (c1 < mn1) ? c1 : mn1;
    mx1 = (h1l > h1r) ? h1l : h1r;
    mx1 = (c1 > mx1) ? c1 : mx1;
    mn2 = (h2l < h2r) ? h2l : h2r;
    mn2 = (c2 < mn2) ? c2 : mn2;
    mx2 = (h2l > h2r) ? h2l : h2r;
    mx2 = (c2 > mx2) ? c2 : mx2;
    d1  = (c1 > mx2) ? c1 - mx2 : ((mn2 > c1) ? mn2 - c1 : '0);
    d2  = (c2 > mx1) ? c2 - mx1 : ((mn1 > c2) ? mn1 - c2 : '0);
    if (bt) begin
      return (d1 < d2) ? d1 : d2;
    end
    return (c1 > c2) ? c1 - c2 : c2 - c1;
  endfunction

  assign advance = !out_valid || !out_stall;
  assign wr_addr = wp + AW'(1);
  assign rd_addr = wp - AW'(cmd.rd_age);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (cmd.write) begin
      wp <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_addr] <= {right_ch2, right_ch1, right_ch0};
    end
    if (advance) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rw_m <= rw_c;
      rw_c <= rw_p;
      rw_p <= rd_data;
    end
    if (cmd.write) begin
      lh0 <= {left_ch2, left_ch1, left_ch0};
      lh1 <= lh0;
      lh2 <= lh1;
    end
  end

  always_comb begin
    lc = cmd.base ? lh1 : lh0;
    ll = cmd.x_zero ? lc : (cmd.base ? lh2 : lh1);
    lr = lh0;
    rl = cmd.at_edge ? rw_c : rw_p;
    for (int i = 0; i < smcv_pkg::CH_N; i++) begin
      diff_c[i] = pix_diff(cfg.use_bt,
                           lc[i*PW +: PW], ll[i*PW +: PW], lr[i*PW +: PW],
                           rw_c[i*PW +: PW], rl[i*PW +: PW], rw_m[i*PW +: PW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_diff  <= diff_c;
      b_oob   <= cmd.oob;
      b_label <= cmd.label;
      b_plast <= cmd.pixel_last;
      b_rlast <= cmd.row_last;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < smcv_pkg::CH_N; i++) begin
      if (smcv_pkg::NC_W'(i) < cfg.colors) begin
        if (cfg.use_sq) begin
          sum = sum + smcv_pkg::COST_W'(b_diff[i]) * smcv_pkg::COST_W'(b_diff[i]);
        end else begin
          sum = sum + smcv_pkg::COST_W'(b_diff[i]);
        end
      end
    end
    if (b_oob) begin
      cost_next = cfg.bad;
    end else if (smcv_pkg::MAXSUM_W'(sum) < cfg.max_sum) begin
      cost_next = sum;
    end else begin
      cost_next = cfg.max_sum[smcv_pkg::COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b_valid) begin
      cost       <= cost_next;
      disparity  <= b_label;
      pixel_last <= b_plast;
      row_last   <= b_rlast;
    end
  end

endmodule

/* hdl/stereo_matching_cost_volume_core.sv */
// ----------------------------------------------------------------------------
// Stereo matching cost volume core
// Per-pixel, per-disparity absolute or Birchfield-Tomasi matching costs, optionally squared.
// ----------------------------------------------------------------------------
// Each accepted request is written into the right window memory and left
// history; while the output does not stall, the costs of a pixel then follow
// as one label per cycle once the right window read pipeline is primed. A
// request that ends a row with a pixel pending yields the costs of both, and
// no new request is taken until its labels are done. The first pixel of a row
// yields nothing until its right neighbour arrives, unless it ends the row. The
// rate is set by the single read port of the right window memory, walked one disparity a cycle.
module stereo_matching_cost_volume_core #(
  parameter int MAX_LABELS = smcv_pkg::MAX_LABELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [smcv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smcv_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [smcv_pkg::PIX_W-1:0]        left_ch0,
  input  logic [smcv_pkg::PIX_W-1:0]        left_ch1,
  input  logic [smcv_pkg::PIX_W-1:0]        left_ch2,
  input  logic [smcv_pkg::PIX_W-1:0]        right_ch0,
  input  logic [smcv_pkg::PIX_W-1:0]        right_ch1,
  input  logic [smcv_pkg::PIX_W-1:0]        right_ch2,
  input  logic                              line_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [smcv_pkg::COST_W-1:0]       cost,
  output logic [smcv_pkg::LABEL_W-1:0]      disparity,
  output logic                              pixel_last,
  output logic                              row_last
);

  smcv_pkg::cfg_t cfg;
  smcv_pkg::cmd_t cmd;
  logic           advance;

  smcv_cfg #(
    .MAX_LABELS (MAX_LABELS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  smcv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .line_end (line_end),
    .in_stall (in_stall),
    .advance  (advance),
    .cfg      (cfg),
    .cmd      (cmd)
  );

  smcv_dp #(
    .MAX_LABELS (MAX_LABELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .left_ch0   (left_ch0),
    .left_ch1   (left_ch1),
    .left_ch2   (left_ch2),
    .right_ch0  (right_ch0),
    .right_ch1  (right_ch1),
    .right_ch2  (right_ch2),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cost       (cost),
    .disparity  (disparity),
    .pixel_last (pixel_last),
    .row_last   (row_last)
  );

endmodule

/* tb/tb_stereo_matching_cost_volume_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stereo matching cost volume core testbench
// Streams rows of left/right pixel pairs through the core under a series of
// register settings and random handshake pressure on both sides. A local
// predictor keeps its own right window, left history and column count and
// queues the costs due for every accepted request; the monitor compares each
// accepted cost, field by field, with the oldest queued one.
// ----------------------------------------------------------------------------
module tb_stereo_matching_cost_volume_core;

  localparam int WIN_DEPTH    = 34;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [smcv_pkg::RGB_W-1:0] left;
    logic [smcv_pkg::RGB_W-1:0] right;
    logic                       last;
  } pix_req_t;

  typedef struct packed {
    logic [smcv_pkg::COST_W-1:0]  cost;
    logic [smcv_pkg::LABEL_W-1:0] disparity;
    logic                         pixel_last;
    logic                         row_last;
  } label_cost_t;

  logic                            clk;
  logic                            rst        = 1'b1;
  logic                            cfg_we     = 1'b0;
  logic [smcv_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [smcv_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                            in_valid   = 1'b0;
  logic                            in_stall;
  logic [smcv_pkg::PIX_W-1:0]      left_ch0   = '0;
  logic [smcv_pkg::PIX_W-1:0]      left_ch1   = '0;
  logic [smcv_pkg::PIX_W-1:0]      left_ch2   = '0;
  logic [smcv_pkg::PIX_W-1:0]      right_ch0  = '0;
  logic [smcv_pkg::PIX_W-1:0]      right_ch1  = '0;
  logic [smcv_pkg::PIX_W-1:0]      right_ch2  = '0;
  logic                            line_end   = 1'b0;
  logic                            out_valid;
  logic                            out_stall  = 1'b0;
  logic [smcv_pkg::COST_W-1:0]     cost;
  logic [smcv_pkg::LABEL_W-1:0]    disparity;
  logic                            pixel_last;
  logic                            row_last;

  stereo_matching_cost_volume_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_ch0   (left_ch0),
    .left_ch1   (left_ch1),
    .left_ch2   (left_ch2),
    .right_ch0  (right_ch0),
    .right_ch1  (right_ch1),
    .right_ch2  (right_ch2),
    .line_end   (line_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cost       (cost),
    .disparity  (disparity),
    .pixel_last (pixel_last),
    .row_last   (row_last)
  );

  // register copies
  logic [smcv_pkg::NL_W-1:0]    num_labels     = smcv_pkg::NL_W'(smcv_pkg::NL_RESET);
  logic [smcv_pkg::NC_W-1:0]    num_colors     = smcv_pkg::NC_W'(smcv_pkg::NC_RESET);
  logic                         use_birchfield = 1'(smcv_pkg::BT_RESET);
  logic                         use_squared    = 1'(smcv_pkg::SQ_RESET);
  logic [smcv_pkg::TRUNC_W-1:0] trunc_limit    = smcv_pkg::TRUNC_W'(smcv_pkg::TRUNC_RESET);

  // predictor state
  logic [smcv_pkg::COL_W-1:0] col_count = '0;
  logic [smcv_pkg::RGB_W-1:0] right_win [WIN_DEPTH];
  logic [smcv_pkg::RGB_W-1:0] left_hist [2];

  pix_req_t    pixel_queue [$];
  label_cost_t pending_costs [$];
  pix_req_t    held_req;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_stereo_matching_cost_volume_core: FAIL");
    $finish;
  end

  function automatic int lo(int a, int b);
    return a < b ? a : b;
  endfunction

  function automatic int hi(int a, int b);
    return a > b ? a : b;
  endfunction

  function automatic int colours_used();
    return num_colors == 0 ? 1 : int'(num_colors);
  endfunction

  function automatic int cost_ceiling();
    return use_squared ? int'(trunc_limit) * int'(trunc_limit)
                       : colours_used() * int'(trunc_limit);
  endfunction

  function automatic int match_cost(logic [smcv_pkg::RGB_W-1:0] lc,
                                    logic [smcv_pkg::RGB_W-1:0] ll,
                                    logic [smcv_pkg::RGB_W-1:0] lr,
                                    logic [smcv_pkg::RGB_W-1:0] rc,
                                    logic [smcv_pkg::RGB_W-1:0] rl,
                                    logic [smcv_pkg::RGB_W-1:0] rr);
    int sum, c1, c2, l1, r1, l2, r2, mn1, mx1, mn2, mx2, diff;
    sum = 0;
    for (int b = 0; b < colours_used(); b++) begin
      c1 = int'(lc[smcv_pkg::PIX_W*b +: smcv_pkg::PIX_W]);
      c2 = int'(rc[smcv_pkg::PIX_W*b +: smcv_pkg::PIX_W]);
      if (use_birchfield) begin
        l1 = (c1 + int'(ll[smcv_pkg::PIX_W*b +: smcv_pkg::PIX_W])) / 2;
        r1 = (c1 + int'(lr[smcv_pkg::PIX_W*b +: smcv_pkg::PIX_W])) / 2;
        l2 = (c2 + int'(rl[smcv_pkg::PIX_W*b +: smcv_pkg::PIX_W])) / 2;
        r2 = (c2 + int'(rr[smcv_pkg::PIX_W*b +: smcv_pkg::PIX_W])) / 2;
        mn1 = lo(c1, lo(l1, r1));
        mx1 = hi(c1, hi(l1, r1));
        mn2 = lo(c2, lo(l2, r2));
        mx2 = hi(c2, hi(l2, r2));
        diff = lo(hi(0, hi(c1 - mx2, mn2 - c1)), hi(0, hi(c2 - mx1, mn1 - c2)));
      end else begin
        diff = c1 > c2 ? c1 - c2 : c2 - c1;
      end
      sum += use_squared ? diff * diff : diff;
    end
    return lo(sum, cost_ceiling());
  endfunction

  // queue every label cost of the left pixel at column x
  task automatic pixel_costs(int x, logic [smcv_pkg::RGB_W-1:0] lc,
                             logic [smcv_pkg::RGB_W-1:0] ll,
                             logic [smcv_pkg::RGB_W-1:0] lr,
                             logic [smcv_pkg::RGB_W-1:0] rr0, bit row_end);
    int labels, worst, oob_cost, c;
    logic [smcv_pkg::RGB_W-1:0] rc, rl, rr;
    label_cost_t res;
    labels = num_labels == 0 ? 1
           : (num_labels > smcv_pkg::MAX_LABELS_DEF ? smcv_pkg::MAX_LABELS_DEF
                                                    : int'(num_labels));
    worst = colours_used() * (use_squared ? smcv_pkg::PIX_MAX_SQ : smcv_pkg::PIX_MAX);
    oob_cost = lo(worst, cost_ceiling());
    if (x == 0) ll = lc;
    for (int d = 0; d < labels; d++) begin
      if (d > x) begin
        c = oob_cost;
      end else begin
        rc = right_win[d];
        rl = (x == d) ? rc : right_win[d+1];
        rr = (d == 0) ? rr0 : right_win[d-1];
        c = match_cost(lc, ll, lr, rc, rl, rr);
      end
      res.cost       = c[smcv_pkg::COST_W-1:0];
      res.disparity  = d[smcv_pkg::LABEL_W-1:0];
      res.pixel_last = (d + 1 == labels);
      res.row_last   = row_end && (d + 1 == labels);
      pending_costs.push_back(res);
    end
  endtask

  always @(posedge clk) begin : drive_pixels
    pix_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (col_count > 0)
          pixel_costs(int'(col_count) - 1, left_hist[0], left_hist[1], held_req.left,
                      held_req.right, 1'b0);
        for (int i = WIN_DEPTH - 1; i > 0; i--) right_win[i] = right_win[i-1];
        right_win[0] = held_req.right;
        left_hist[1] = left_hist[0];
        left_hist[0] = held_req.left;
        if (held_req.last) begin
          pixel_costs(int'(col_count), held_req.left, left_hist[1], held_req.left,
                      held_req.right, 1'b1);
          col_count = '0;
        end else if (col_count != smcv_pkg::COL_MAX) begin
          col_count = col_count + 1'b1;
        end
      end
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = pixel_queue.pop_front();
          held_req  = nxt;
          in_valid  <= 1'b1;
          left_ch0  <= nxt.left[7:0];
          left_ch1  <= nxt.left[15:8];
          left_ch2  <= nxt.left[23:16];
          right_ch0 <= nxt.right[7:0];
          right_ch1 <= nxt.right[15:8];
          right_ch2 <= nxt.right[23:16];
          line_end  <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_costs
    label_cost_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_costs.size() == 0) begin
        $error("unexpected cost: disparity %0d, cost %0d", disparity, cost);
        mismatch_count++;
      end else begin
        want = pending_costs.pop_front();
        if (cost !== want.cost) begin
          $error("cost: expected %0d, got %0d", want.cost, cost);
          mismatch_count++;
        end
        if (disparity !== want.disparity) begin
          $error("disparity: expected %0d, got %0d", want.disparity, disparity);
          mismatch_count++;
        end
        if (pixel_last !== want.pixel_last) begin
          $error("pixel_last: expected %0d, got %0d", want.pixel_last, pixel_last);
          mismatch_count++;
        end
        if (row_last !== want.row_last) begin
          $error("row_last: expected %0d, got %0d", want.row_last, row_last);
          mismatch_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic write_reg(smcv_pkg::cfg_reg_t idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[smcv_pkg::CFG_DATA_W-1:0];
    case (idx)
      smcv_pkg::REG_NUM_LABELS: num_labels     = val[smcv_pkg::NL_W-1:0];
      smcv_pkg::REG_NUM_COLORS: num_colors     = val[smcv_pkg::NC_W-1:0];
      smcv_pkg::REG_USE_BT:     use_birchfield = val[0];
      smcv_pkg::REG_USE_SQ:     use_squared    = val[0];
      smcv_pkg::REG_TRUNC:      trunc_limit    = val[smcv_pkg::TRUNC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int nl, int nc, int bt, int sq, int tr);
    write_reg(smcv_pkg::REG_NUM_LABELS, nl);
    write_reg(smcv_pkg::REG_NUM_COLORS, nc);
    write_reg(smcv_pkg::REG_USE_BT, bt);
    write_reg(smcv_pkg::REG_USE_SQ, sq);
    write_reg(smcv_pkg::REG_TRUNC, tr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_req(logic [smcv_pkg::RGB_W-1:0] l, logic [smcv_pkg::RGB_W-1:0] r,
                          logic last);
    pix_req_t req;
    req.left  = l;
    req.right = r;
    req.last  = last;
    pixel_queue.push_back(req);
  endtask

  function automatic logic [smcv_pkg::RGB_W-1:0] rand_pix();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return w[smcv_pkg::RGB_W-1:0];
    endcase
  endfunction

  function automatic logic [smcv_pkg::RGB_W-1:0] near_pix(logic [smcv_pkg::RGB_W-1:0] p);
    logic [smcv_pkg::RGB_W-1:0] q;
    int v;
    for (int b = 0; b < smcv_pkg::CH_N; b++) begin
      v = int'(p[smcv_pkg::PIX_W*b +: smcv_pkg::PIX_W]) + int'($urandom_range(12)) - 6;
      v = hi(0, lo(smcv_pkg::PIX_MAX, v));
      q[smcv_pkg::PIX_W*b +: smcv_pkg::PIX_W] = v[smcv_pkg::PIX_W-1:0];
    end
    return q;
  endfunction

  task automatic push_row(int len);
    logic [smcv_pkg::RGB_W-1:0] l;
    for (int i = 0; i < len; i++) begin
      l = rand_pix();
      push_req(l, ($urandom_range(3) == 0) ? rand_pix() : near_pix(l), i == len - 1);
    end
  endtask

  // hold until every request and cost has gone, then let the core settle
  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid || pending_costs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : run
    int nl, tr, row_len, budget;
    for (int i = 0; i < WIN_DEPTH; i++) right_win[i] = '0;
    left_hist[0] = '0;
    left_hist[1] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle = 31;
    recv_idle = 69;

    // reset settings: single-pixel row, then short rows of extremes
    push_req(24'hffffff, 24'h000000, 1'b1);
    push_req(24'h000000, 24'h000000, 1'b0);
    push_req(24'hffffff, 24'hffffff, 1'b0);
    push_req(24'h00ff00, 24'hff00ff, 1'b0);
    push_req(24'h808080, 24'h7f817e, 1'b1);
    push_req(24'hffffff, 24'h000000, 1'b0);
    push_req(24'h000000, 24'hffffff, 1'b0);
    push_req(24'hffffff, 24'hfefefe, 1'b0);
    push_req(24'h010203, 24'h000000, 1'b0);
    push_req(24'h102030, 24'h112233, 1'b0);
    push_req(24'hff0000, 24'hff0000, 1'b1);
    drain();

    // label and colour counts of zero, squared absolute difference
    configure(0, 0, 0, 1, 1023);
    push_req(24'hffffff, 24'h000000, 1'b0);
    push_req(24'h000000, 24'hffffff, 1'b0);
    push_req(24'ha5a5a5, 24'h5a5a5a, 1'b1);
    push_req(24'h123456, 24'h654321, 1'b1);
    drain();

    // label count above the maximum, zero threshold
    configure(40, 2, 1, 0, 0);
    push_req(24'hffffff, 24'h000000, 1'b0);
    push_req(24'h00ff00, 24'hff00ff, 1'b0);
    push_req(24'haaaaaa, 24'h555555, 1'b1);
    drain();

    // full labels, squared Birchfield-Tomasi at the widest threshold
    configure(32, 3, 1, 1, 1023);
    push_req(24'hffffff, 24'h000000, 1'b0);
    push_req(24'h000000, 24'hffffff, 1'b0);
    push_req(24'hffffff, 24'h000000, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle = 69;
        recv_idle = 31;
      end else if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case ($urandom_range(9))
        0: nl = 0;
        1: nl = 1;
        2: nl = 32;
        3: nl = $urandom_range(63, 33);
        default: nl = $urandom_range(31, 2);
      endcase
      case ($urandom_range(5))
        0: tr = 0;
        1: tr = 1023;
        2: tr = $urandom_range(40, 1);
        default: tr = $urandom_range(1023);
      endcase
      configure(nl, $urandom_range(3), $urandom_range(1), $urandom_range(1), tr);
      // long row past the column count saturation
      if (p == 6) push_row(70);
      budget = 10;
      while (budget > 0) begin
        row_len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        push_row(row_len);
        budget -= row_len;
      end
      drain();
    end

    if (mismatch_count == 0)
      $display("tb_stereo_matching_cost_volume_core: PASS");
    else
      $display("tb_stereo_matching_cost_volume_core: FAIL");
    $finish;
  end

endmodule
